FILE: src/qrs_pkg.sv
// Shared types and defaults for the quadratic root solver.
// Has no dependencies; the top level imports it.
package qrs_pkg;

    // Default coefficient format: Q16.16 in a 32-bit word.
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // Classification of one coefficient set.
    typedef enum logic [1:0] {
        CASE_NOT_QUAD = 2'd0,
        CASE_TWO_ROOTS = 2'd1,
        CASE_ONE_ROOT = 2'd2,
        CASE_NO_REAL = 2'd3
    } root_case_t;

endpackage

FILE: src/qrs_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// No dependencies; a sideband word travels along with each radicand.
module qrs_isqrt #(
    parameter int RES_W = 33,
    parameter int SIDE_W = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2*RES_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [RES_W-1:0]     out_root,
    output logic [SIDE_W-1:0]    out_side
);

    logic [RES_W-1:0]             valid_reg;
    logic [RES_W-1:0][2*RES_W-1:0] rad_reg;
    logic [RES_W-1:0][RES_W+1:0]  rem_reg;
    logic [RES_W-1:0][RES_W-1:0]  root_reg;
    logic [RES_W-1:0][SIDE_W-1:0] side_reg;

    genvar k;
    generate
        for (k = 0; k < RES_W; k++) begin : g_stage
            logic                 prev_valid;
            logic [2*RES_W-1:0]   prev_rad;
            logic [RES_W+1:0]     prev_rem;
            logic [RES_W-1:0]     prev_root;
            logic [SIDE_W-1:0]    prev_side;
            logic [RES_W+1:0]     rem_sh;
            logic [RES_W+1:0]     trial;
            logic                 fits;

            if (k == 0) begin : g_first
                assign prev_valid = in_valid;
                assign prev_rad   = in_rad;
                assign prev_rem   = '0;
                assign prev_root  = '0;
                assign prev_side  = in_side;
            end else begin : g_next
                assign prev_valid = valid_reg[k-1];
                assign prev_rad   = rad_reg[k-1];
                assign prev_rem   = rem_reg[k-1];
                assign prev_root  = root_reg[k-1];
                assign prev_side  = side_reg[k-1];
            end

            // Bring down the next two radicand bits and try the next root bit.
            assign rem_sh = {prev_rem[RES_W-1:0], prev_rad[2*RES_W-1 -: 2]};
            assign trial  = {prev_root, 2'b01};
            assign fits   = rem_sh >= trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= prev_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k]  <= {prev_rad[2*RES_W-3:0], 2'b00};
                    rem_reg[k]  <= fits ? rem_sh - trial : rem_sh;
                    root_reg[k] <= {prev_root[RES_W-2:0], fits};
                    side_reg[k] <= prev_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[RES_W-1];
    assign out_root  = root_reg[RES_W-1];
    assign out_side  = side_reg[RES_W-1];

endmodule

FILE: src/qrs_div.sv
// Pipelined two-lane restoring divider sharing one divisor, one quotient
// bit per stage. No dependencies; a sideband word travels with each pair.
module qrs_div #(
    parameter int QUO_W = 50,
    parameter int DEN_W = 33,
    parameter int SIDE_W = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [1:0][QUO_W-1:0]  in_num,
    input  logic [DEN_W-1:0]       in_den,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic [1:0][QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0]      out_side
);

    logic [QUO_W-1:0]                   valid_reg;
    logic [QUO_W-1:0][1:0][QUO_W-1:0]   num_reg;
    logic [QUO_W-1:0][1:0][DEN_W-1:0]   rem_reg;
    logic [QUO_W-1:0][1:0][QUO_W-1:0]   quo_reg;
    logic [QUO_W-1:0][DEN_W-1:0]        den_reg;
    logic [QUO_W-1:0][SIDE_W-1:0]       side_reg;

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            logic                  prev_valid;
            logic [1:0][QUO_W-1:0] prev_num;
            logic [1:0][DEN_W-1:0] prev_rem;
            logic [1:0][QUO_W-1:0] prev_quo;
            logic [DEN_W-1:0]      prev_den;
            logic [SIDE_W-1:0]     prev_side;
            logic [1:0][DEN_W-1:0] rem_next;
            logic [1:0]            fits;

            if (k == 0) begin : g_first
                assign prev_valid = in_valid;
                assign prev_num   = in_num;
                assign prev_rem   = '0;
                assign prev_quo   = '0;
                assign prev_den   = in_den;
                assign prev_side  = in_side;
            end else begin : g_next
                assign prev_valid = valid_reg[k-1];
                assign prev_num   = num_reg[k-1];
                assign prev_rem   = rem_reg[k-1];
                assign prev_quo   = quo_reg[k-1];
                assign prev_den   = den_reg[k-1];
                assign prev_side  = side_reg[k-1];
            end

            // Shift in the next dividend bit and subtract the divisor if it fits.
            always_comb begin
                logic [DEN_W:0] rem_sh;
                logic [DEN_W:0] diff;
                for (int i = 0; i < 2; i++) begin
                    rem_sh      = {prev_rem[i], prev_num[i][QUO_W-1]};
                    diff        = rem_sh - {1'b0, prev_den};
                    fits[i]     = rem_sh >= {1'b0, prev_den};
                    rem_next[i] = fits[i] ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= prev_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    for (int i = 0; i < 2; i++) begin
                        num_reg[k][i] <= prev_num[i] << 1;
                        quo_reg[k][i] <= {prev_quo[i][QUO_W-2:0], fits[i]};
                    end
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= prev_den;
                    side_reg[k] <= prev_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

FILE: src/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: products, discriminant, root
// and divide pipelines. Depends on qrs_pkg, qrs_isqrt and qrs_div.
//
// Usage:
//   A coefficient word (a, b, c, signed fixed point) enters on the s_ stream;
//   one result word (case, two roots, overflow flag) leaves on the m_ stream
//   for every word taken. Words are independent.
//   Throughput: one word per cycle while the receiver takes results.
//   Stages: the product and discriminant stages, the square root pipeline,
//   which yields one bit per stage (WORD_BITS+1 stages), the numerator
//   stage, the divider, which yields one quotient bit per stage
//   (WORD_BITS+2+FRAC_BITS stages), and the output stage. Default format: Q16.16.
//   Stall: the whole pipeline holds while a result waits in the output
//   register and m_tready is low; s_tready is low only then.
//   Reset: aresetn, synchronous and active low, empties the pipeline; no
//   result is pending afterwards.
module quadratic_root_solver_unit
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // coef_a, coef_b, coef_c from the lowest bit up
    input  logic [((3*WORD_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // root_case, root_one, root_two, overflow from the lowest bit up
    output logic [((2*WORD_BITS+10)/8)*8-1:0]  m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    localparam int W      = WORD_BITS;
    localparam int DW     = 2*W + 3;
    localparam int SQ_W   = W + 1;
    localparam int MAG_W  = W + 2;
    localparam int QUO_W  = W + 2 + FRAC_BITS;
    localparam int DEN_W  = W + 1;
    localparam int OUT_W  = ((2*W+10)/8)*8;

    localparam logic [QUO_W-1:0] POS_LIM = {{(FRAC_BITS+3){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QUO_W-1:0] NEG_LIM = POS_LIM + 1'b1;

    typedef struct packed {
        root_case_t     kind;
        logic           a_neg;
        logic [W-1:0]   b;
        logic [W-1:0]   ua;
    } sq_side_t;

    typedef struct packed {
        root_case_t     kind;
        logic           neg_one;
        logic           neg_two;
    } dv_side_t;

    logic en;

    // The pipeline moves whenever the output register is free or being read.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: magnitudes and the two products.
    logic signed [W-1:0] in_a, in_b, in_c;
    logic [W-1:0]        mag_a, mag_b, mag_c;

    assign in_a  = s_tdata[W-1:0];
    assign in_b  = s_tdata[2*W-1:W];
    assign in_c  = s_tdata[3*W-1:2*W];
    assign mag_a = in_a[W-1] ? -in_a : in_a;
    assign mag_b = in_b[W-1] ? -in_b : in_b;
    assign mag_c = in_c[W-1] ? -in_c : in_c;

    logic              p1_valid_reg;
    logic [2*W-1:0]    bb_reg, ac_reg;
    logic              ac_neg_reg, a_zero_reg, a_neg_reg;
    logic [W-1:0]      b_reg, ua_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bb_reg     <= mag_b * mag_b;
            ac_reg     <= mag_a * mag_c;
            ac_neg_reg <= in_a[W-1] ^ in_c[W-1];
            a_zero_reg <= in_a == '0;
            a_neg_reg  <= in_a[W-1];
            b_reg      <= in_b;
            ua_reg     <= mag_a;
        end
    end

    // Stage 2: discriminant and classification.
    logic [DW-1:0] disc;
    root_case_t    kind_next;

    always_comb begin
        if (ac_neg_reg) begin
            disc = {3'b000, bb_reg} + {1'b0, ac_reg, 2'b00};
        end else begin
            disc = {3'b000, bb_reg} - {1'b0, ac_reg, 2'b00};
        end
        if (a_zero_reg) begin
            kind_next = CASE_NOT_QUAD;
        end else if (disc[DW-1]) begin
            kind_next = CASE_NO_REAL;
        end else if (disc == '0) begin
            kind_next = CASE_ONE_ROOT;
        end else begin
            kind_next = CASE_TWO_ROOTS;
        end
    end

    logic              p2_valid_reg;
    logic [2*SQ_W-1:0] rad_reg;
    sq_side_t          sq_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg           <= disc[DW-1] ? '0 : disc[2*SQ_W-1:0];
            sq_side_reg.kind  <= kind_next;
            sq_side_reg.a_neg <= a_neg_reg;
            sq_side_reg.b     <= b_reg;
            sq_side_reg.ua    <= ua_reg;
        end
    end

    // Square root of the discriminant.
    logic            sq_valid;
    logic [SQ_W-1:0] sq_root;
    sq_side_t        sq_side;

    qrs_isqrt #(
        .RES_W  (SQ_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .in_rad    (rad_reg),
        .in_side   (sq_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Numerator stage: -b plus and minus the root, as sign and magnitude.
    logic signed [W+2:0] neg_b, num_one, num_two;
    logic [MAG_W-1:0]    mag_one, mag_two;

    assign neg_b   = -$signed({{3{sq_side.b[W-1]}}, sq_side.b});
    assign num_one = neg_b + $signed({2'b00, sq_root});
    assign num_two = neg_b - $signed({2'b00, sq_root});
    assign mag_one = num_one[W+2] ? MAG_W'(-num_one) : MAG_W'(num_one);
    assign mag_two = num_two[W+2] ? MAG_W'(-num_two) : MAG_W'(num_two);

    logic                   p3_valid_reg;
    logic [1:0][QUO_W-1:0]  dvd_reg;
    logic [DEN_W-1:0]       den_reg;
    dv_side_t               dv_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_reg[0]          <= QUO_W'(mag_one) << FRAC_BITS;
            dvd_reg[1]          <= QUO_W'(mag_two) << FRAC_BITS;
            den_reg             <= {sq_side.ua, 1'b0};
            dv_side_reg.kind    <= sq_side.kind;
            dv_side_reg.neg_one <= num_one[W+2] ^ sq_side.a_neg;
            dv_side_reg.neg_two <= num_two[W+2] ^ sq_side.a_neg;
        end
    end

    // Division of both numerators by 2a.
    logic                  dv_valid;
    logic [1:0][QUO_W-1:0] dv_quo;
    dv_side_t              dv_side;

    qrs_div #(
        .QUO_W  (QUO_W),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(dv_side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p3_valid_reg),
        .in_num    (dvd_reg),
        .in_den    (den_reg),
        .in_side   (dv_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // Output stage: saturate, apply sign, clear roots when none exist.
    logic [QUO_W-1:0] lim_one, lim_two, sat_one, sat_two;
    logic             over_one, over_two, has_roots;
    logic [W-1:0]     root_one, root_two;
    logic [OUT_W-1:0] m_tdata_next;

    always_comb begin
        lim_one   = dv_side.neg_one ? NEG_LIM : POS_LIM;
        lim_two   = dv_side.neg_two ? NEG_LIM : POS_LIM;
        over_one  = dv_quo[0] > lim_one;
        over_two  = dv_quo[1] > lim_two;
        sat_one   = over_one ? lim_one : dv_quo[0];
        sat_two   = over_two ? lim_two : dv_quo[1];
        root_one  = dv_side.neg_one ? -sat_one[W-1:0] : sat_one[W-1:0];
        root_two  = dv_side.neg_two ? -sat_two[W-1:0] : sat_two[W-1:0];
        has_roots = dv_side.kind == CASE_TWO_ROOTS || dv_side.kind == CASE_ONE_ROOT;
        m_tdata_next = '0;
        m_tdata_next[1:0] = dv_side.kind;
        if (has_roots) begin
            m_tdata_next[W+1:2]     = root_one;
            m_tdata_next[2*W+1:W+2] = root_two;
            m_tdata_next[2*W+2]     = over_one | over_two;
        end
    end

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: bench/quadratic_root_solver_unit_test.sv
// Self-checking bench for quadratic_root_solver_unit: directed table, then random words.
// Depends on qrs_pkg and the solver RTL; results checked against the table or a local predictor.
module quadratic_root_solver_unit_test
    import qrs_pkg::*;
();

    localparam int FB = FRAC_BITS_DEF;
    localparam int WB = WORD_BITS_DEF;
    localparam int N_RANDOM = 1530;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        root_case_t     kind;
        logic [WB-1:0]  r1;
        logic [WB-1:0]  r2;
        logic           ovf;
    } roots_t;

    typedef struct {
        logic [WB-1:0] a;
        logic [WB-1:0] b;
        logic [WB-1:0] c;
        bit            typed;
        roots_t        want;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [95:0]  s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;

    roots_t pending_roots[$];
    int     errors = 0;
    bit     no_idle = 1'b0;
    bit     hold_sink = 1'b0;
    bit     stim_done = 1'b0;
    int     quiet_cycles = 0;

    quadratic_root_solver_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    always #5 aclk = ~aclk;

    // Divide a numerator by 2a in fixed point, truncating and saturating.
    function automatic logic [WB-1:0] scaled_root(input longint num, input bit a_neg,
                                                  input logic [127:0] den, inout bit ovf);
        logic [127:0] mag_n;
        logic [127:0] q;
        logic [127:0] lim;
        bit neg;
        mag_n = (num < 0) ? 128'(-num) : 128'(num);
        neg = (num < 0) != a_neg;
        lim = neg ? (128'd1 << (WB - 1)) : (128'd1 << (WB - 1)) - 1;
        q = (mag_n << FB) / den;
        if (q > lim) begin
            q = lim;
            ovf = 1'b1;
        end
        return neg ? WB'(-q) : WB'(q);
    endfunction

    // Classify the equation and compute both roots from one coefficient word.
    function automatic roots_t solve_quadratic(input logic [WB-1:0] ra, rb, rc);
        logic signed [127:0] a, b, c, disc;
        logic [127:0] t, sq;
        roots_t res;
        bit ovf;
        a = 128'($signed(ra));
        b = 128'($signed(rb));
        c = 128'($signed(rc));
        res = '{CASE_NOT_QUAD, '0, '0, 1'b0};
        ovf = 1'b0;
        sq = '0;
        if (a == 0) return res;
        disc = b * b - 4 * a * c;
        if (disc < 0) begin
            res.kind = CASE_NO_REAL;
            return res;
        end
        // Floor square root, one bit at a time from the top.
        for (int i = 63; i >= 0; i--) begin
            t = sq | (128'd1 << i);
            if (t * t <= disc) sq = t;
        end
        res.kind = (disc > 0) ? CASE_TWO_ROOTS : CASE_ONE_ROOT;
        res.r1 = scaled_root(longint'(-b) + longint'(sq), a < 0,
                             (a < 0 ? -a : a) << 1, ovf);
        res.r2 = scaled_root(longint'(-b) - longint'(sq), a < 0,
                             (a < 0 ? -a : a) << 1, ovf);
        res.ovf = ovf;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [WB-1:0] got, want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // Offer one coefficient word; record its expectation when it is taken.
    task automatic send_word(input logic [WB-1:0] a, b, c, input bit typed, input roots_t want);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        pending_roots.push_back(typed ? want : solve_quadratic(a, b, c));
    endtask

    // Random coefficient words, weighted toward the interesting classes.
    task automatic random_word(output logic [WB-1:0] a, b, c);
        int sel;
        int k;
        sel = $urandom_range(99);
        a = $urandom;
        b = $urandom;
        c = $urandom;
        if (sel < 30) begin
            a = WB'($signed($urandom_range(2 ** 21)) - 2 ** 20);
            b = WB'($signed($urandom_range(2 ** 21)) - 2 ** 20);
            c = WB'($signed($urandom_range(2 ** 21)) - 2 ** 20);
        end else if (sel < 40) begin
            a = '0;
        end else if (sel < 55) begin
            // b*b == 4ac: a single root.
            k = $signed($urandom_range(200)) - 100;
            a = WB'($signed($urandom_range(2000)) - 1000);
            if (a == 0) a = 1;
            b = WB'(2 * $signed(a) * k);
            c = WB'($signed(a) * k * k);
        end else if (sel < 62) begin
            c = '0;
        end else if (sel < 68) begin
            b = '0;
        end
    endtask

    // Stimulus: reset, directed table, random words with a drain pause.
    initial begin
        row_t rows[$];
        logic [WB-1:0] a, b, c;
        roots_t none;
        none = '{CASE_NOT_QUAD, '0, '0, 1'b0};
        rows = '{
            '{32'h0, 32'h0, 32'h0, 1, none},
            '{32'h0, 32'h7fffffff, 32'h80000000, 1, none},
            '{32'h00010000, 32'h0, 32'hfffc0000, 1,
              '{CASE_TWO_ROOTS, 32'h00020000, 32'hfffe0000, 1'b0}},
            '{32'h00010000, 32'h0, 32'h00010000, 1, '{CASE_NO_REAL, '0, '0, 1'b0}},
            '{32'h00010000, 32'hfffe0000, 32'h00010000, 1,
              '{CASE_ONE_ROOT, 32'h00010000, 32'h00010000, 1'b0}},
            '{32'h00000001, 32'h7fffffff, 32'h0, 0, none},
            '{32'h00000001, 32'h80000000, 32'h0, 0, none},
            '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, none},
            '{32'h80000000, 32'h80000000, 32'h80000000, 0, none},
            '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, none},
            '{32'h7fffffff, 32'h80000000, 32'h80000000, 0, none},
            '{32'hffffffff, 32'h0, 32'h7fffffff, 0, none},
            '{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, none},
            '{32'h00000001, 32'h00000002, 32'h00000001, 0, none},
            '{32'h80000000, 32'h0, 32'h0, 0, none},
            '{32'h7fffffff, 32'h0, 32'h80000000, 0, none},
            '{32'hfffe0000, 32'h00050000, 32'hfffd0000, 0, none},
            '{32'h00000001, 32'h80000000, 32'h7fffffff, 0, none}
        };
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (rows[i]) send_word(rows[i].a, rows[i].b, rows[i].c, rows[i].typed, rows[i].want);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_sink = 1'b1;
            if (n == 700) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (pending_roots.size() != 0) @(negedge aclk);
            end
            no_idle = (n >= 900 && n < 1150);
            random_word(a, b, c);
            send_word(a, b, c, 1'b0, none);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random backpressure plus one long hold-off.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_sink = 1'b0;
            end
            m_tready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    // Check each result word against the oldest expectation.
    always @(posedge aclk) begin
        roots_t want;
        if (m_tvalid && m_tready) begin
            if (pending_roots.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[WB-1:0], '0);
            end else begin
                want = pending_roots.pop_front();
                if (m_tdata[1:0] != want.kind)
                    report_mismatch("root_case", WB'(m_tdata[1:0]), WB'(want.kind));
                if (m_tdata[WB+1:2] != want.r1)
                    report_mismatch("root_one", m_tdata[WB+1:2], want.r1);
                if (m_tdata[2*WB+1:WB+2] != want.r2)
                    report_mismatch("root_two", m_tdata[2*WB+1:WB+2], want.r2);
                if (m_tdata[2*WB+2] != want.ovf)
                    report_mismatch("overflow", WB'(m_tdata[2*WB+2]), WB'(want.ovf));
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // End of run: drain, settle, then the verdict.
    initial begin
        wait (stim_done);
        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_roots.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
